/* hw/rtl/tsq_pkg.sv */
package tsq_pkg;

    localparam int COORD_BITS_DEF = 20;

    // configuration register widths and reset values
    localparam int HALF_W_BITS = 14;
    localparam int HEEL_F_BITS = 12;
    localparam logic [HALF_W_BITS-1:0] HALF_W_RESET = 14'd1280;
    localparam logic [HEEL_F_BITS-1:0] HEEL_F_RESET = 12'd768;
    localparam int ADDR_BITS = 3;

    // quotient of |d| * W / L never exceeds W, so it fits the width of W plus one
    localparam int QUOT_BITS = HALF_W_BITS + 1;
    // round(q * H / 256) and round(W * H / 256)
    localparam int HEEL_BITS = QUOT_BITS + 5;

    localparam int FIFO_DEPTH = 4;

    // end codes that move an end
    localparam logic [3:0] CAP_EXT  = 4'd2;
    localparam logic [3:0] CAP_HEEL = 4'd3;

    typedef enum logic [1:0] {
        KIND_VERT,
        KIND_HORZ,
        KIND_DIAG
    } t_kind;

    typedef enum logic {
        REG_HALF_WIDTH,
        REG_HEEL_FACTOR
    } t_reg;

endpackage

/* hw/rtl/tsq_fifo.sv */
module tsq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tsq_pkg::FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_nempty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;

    assign o_full   = (r_cnt == (AW+1)'(DEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_rdata  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (AW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

/* hw/rtl/tsq_front.sv */
module tsq_front #(
    parameter int COORD_BITS = tsq_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [4*COORD_BITS+7:0]             i_data,
    output logic                                o_push,
    input  logic                                i_full,
    output logic [6*COORD_BITS+12:0]            o_ent
);

    localparam int C  = COORD_BITS;
    localparam int D  = C + 1;
    localparam int EW = 4*C + 11 + 2*D;

    logic signed [C-1:0] w_ax, w_ay, w_bx, w_by;
    logic [3:0]          w_ca, w_cb;
    logic signed [C-1:0] w_x1, w_y1, w_x2, w_y2;
    logic [3:0]          w_c1, w_c2;
    logic                w_swap, w_eqx;
    logic [D-1:0]        w_dx, w_dy, w_my;
    tsq_pkg::t_kind      w_kind;
    logic [EW-1:0]       n_ent;

    logic                r_valid;
    logic [EW-1:0]       r_ent;

    assign w_ax = i_data[0*C +: C];
    assign w_ay = i_data[1*C +: C];
    assign w_bx = i_data[2*C +: C];
    assign w_by = i_data[3*C +: C];
    assign w_ca = i_data[4*C +: 4];
    assign w_cb = i_data[4*C+4 +: 4];

    always_comb begin
        w_eqx  = (w_ax == w_bx);
        w_swap = w_eqx ? (w_ay > w_by) : (w_ax > w_bx);
        w_x1   = w_swap ? w_bx : w_ax;
        w_y1   = w_swap ? w_by : w_ay;
        w_x2   = w_swap ? w_ax : w_bx;
        w_y2   = w_swap ? w_ay : w_ay ^ w_ay ^ w_by;
        w_c1   = w_swap ? w_cb : w_ca;
        w_c2   = w_swap ? w_ca : w_cb;
        if (w_eqx) begin
            w_kind = tsq_pkg::KIND_VERT;
        end else if (w_ay == w_by) begin
            w_kind = tsq_pkg::KIND_HORZ;
        end else begin
            w_kind = tsq_pkg::KIND_DIAG;
        end
        // x2 >= x1 after ordering, so dx is a magnitude already
        w_dx  = D'(w_x2) - D'(w_x1);
        w_dy  = D'(w_y2) - D'(w_y1);
        w_my  = w_dy[D-1] ? (~w_dy + D'(1)) : w_dy;
        n_ent = {w_my, w_dx, w_dy[D-1], w_kind, w_c2, w_c1, w_y2, w_x2, w_y1, w_x1};
    end

    // hold a classified beat until the queue takes it
    assign o_ready = !r_valid || !i_full;
    assign o_push  = r_valid && !i_full;
    assign o_ent   = r_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_ent <= n_ent;
        end
    end

endmodule

/* hw/rtl/tsq_back.sv */
module tsq_back #(
    parameter int COORD_BITS = tsq_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_ent_valid,
    output logic                                o_pop,
    input  logic [6*COORD_BITS+12:0]            i_ent,
    input  logic [tsq_pkg::HALF_W_BITS-1:0]     i_half_width,
    input  logic [tsq_pkg::HEEL_F_BITS-1:0]     i_heel,
    input  logic [tsq_pkg::HEEL_BITS-1:0]       i_e3,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [8*COORD_BITS-1:0]             o_data
);

    localparam int C    = COORD_BITS;
    localparam int D    = C + 1;
    localparam int SW   = 2*D;
    localparam int LW   = D + 1;
    localparam int PWID = D + tsq_pkg::HALF_W_BITS;
    localparam int NW   = D + 16;
    localparam int QB   = tsq_pkg::QUOT_BITS;
    localparam int HB   = tsq_pkg::HEEL_BITS;
    localparam int HPW  = QB + tsq_pkg::HEEL_F_BITS + 1;
    localparam int P_L  = D + 2;
    localparam int P_N  = D + 3;
    localparam int P_H  = D + QB + 4;
    localparam int NS   = D + QB + 5;
    localparam int OW   = ((C > HB) ? C : HB) + 3;
    localparam logic signed [OW-1:0] S_MAX = {{(OW-C+1){1'b0}}, {(C-1){1'b1}}};
    localparam logic signed [OW-1:0] S_MIN = ~S_MAX;
    localparam logic [63:0] HALVE_LIM = 64'h0000_0000_8000_0000;

    logic w_adv;

    // carried fields, one slot per stage
    logic                r_cv [NS];
    logic signed [C-1:0] r_x1 [NS];
    logic signed [C-1:0] r_y1 [NS];
    logic signed [C-1:0] r_x2 [NS];
    logic signed [C-1:0] r_y2 [NS];
    logic [3:0]          r_c1 [NS];
    logic [3:0]          r_c2 [NS];
    tsq_pkg::t_kind      r_kd [NS];
    logic                r_dn [NS];
    logic                r_hv [NS];
    logic [D-1:0]        r_mx [NS];
    logic [D-1:0]        r_my [NS];

    logic [D-1:0]        w_emx, w_emy, w_hmx, w_hmy;
    logic                w_ehv;
    logic [SW-1:0]       w_sqx, w_sqy;
    logic [SW-1:0]       r_sqx, r_sqy;
    logic [SW-1:0]       r_acc  [D+1];
    logic [SW-1:0]       r_root [D+1];
    logic [D-1:0]        w_root;
    logic [LW-1:0]       w_len, r_len;
    logic [PWID-1:0]     w_px, w_py, r_px, r_py;
    logic [LW-1:0]       r_dl  [QB+1];
    logic [NW-1:0]       r_rx  [QB+1];
    logic [NW-1:0]       r_ry  [QB+1];
    logic [QB-1:0]       r_qx  [QB+1];
    logic [QB-1:0]       r_qy  [QB+1];
    logic [HPW-1:0]      w_hpx, w_hpy;
    logic [QB-1:0]       r_nx, r_ny;
    logic [HB-1:0]       r_hx, r_hy;
    logic signed [OW-1:0] w_cr [8];
    logic                r_ov;
    logic [8*C-1:0]      r_odata;

    function automatic logic signed [OW-1:0] pick_ext(
        input logic [3:0] cap,
        input logic signed [OW-1:0] ext_a,
        input logic signed [OW-1:0] ext_b
    );
        logic signed [OW-1:0] res;
        if (cap == tsq_pkg::CAP_EXT) begin
            res = ext_a;
        end else if (cap == tsq_pkg::CAP_HEEL) begin
            res = ext_b;
        end else begin
            res = '0;
        end
        return res;
    endfunction

    function automatic logic [C-1:0] sat(input logic signed [OW-1:0] v);
        logic signed [OW-1:0] t;
        t = v;
        if (v > S_MAX) begin
            t = S_MAX;
        end else if (v < S_MIN) begin
            t = S_MIN;
        end
        return t[C-1:0];
    endfunction

    // advance the whole pipe unless the output beat is stalled
    assign w_adv   = !r_ov || i_ready;
    assign o_pop   = w_adv && i_ent_valid;
    assign o_valid = r_ov;
    assign o_data  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_cv[k] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_cv[0] <= i_ent_valid;
            for (int k = 1; k < NS; k++) begin
                r_cv[k] <= r_cv[k-1];
            end
            r_ov <= r_cv[NS-1];
        end
    end

    // stage 0: unpack, halve very long deltas, square
    assign w_emx = i_ent[4*C+11 +: D];
    assign w_emy = i_ent[4*C+11+D +: D];
    assign w_ehv = (64'(w_emx) >= HALVE_LIM) || (64'(w_emy) >= HALVE_LIM);
    assign w_hmx = w_ehv ? (w_emx >> 1) : w_emx;
    assign w_hmy = w_ehv ? (w_emy >> 1) : w_emy;
    assign w_sqx = w_hmx * w_hmx;
    assign w_sqy = w_hmy * w_hmy;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_x1[0] <= i_ent[0*C +: C];
            r_y1[0] <= i_ent[1*C +: C];
            r_x2[0] <= i_ent[2*C +: C];
            r_y2[0] <= i_ent[3*C +: C];
            r_c1[0] <= i_ent[4*C +: 4];
            r_c2[0] <= i_ent[4*C+4 +: 4];
            r_kd[0] <= tsq_pkg::t_kind'(i_ent[4*C+8 +: 2]);
            r_dn[0] <= i_ent[4*C+10];
            r_hv[0] <= w_ehv;
            r_mx[0] <= w_emx;
            r_my[0] <= w_emy;
            for (int k = 1; k < NS; k++) begin
                r_x1[k] <= r_x1[k-1];
                r_y1[k] <= r_y1[k-1];
                r_x2[k] <= r_x2[k-1];
                r_y2[k] <= r_y2[k-1];
                r_c1[k] <= r_c1[k-1];
                r_c2[k] <= r_c2[k-1];
                r_kd[k] <= r_kd[k-1];
                r_dn[k] <= r_dn[k-1];
                r_hv[k] <= r_hv[k-1];
                r_mx[k] <= r_mx[k-1];
                r_my[k] <= r_my[k-1];
            end
            r_sqx     <= w_sqx;
            r_sqy     <= w_sqy;
            r_acc[0]  <= r_sqx + r_sqy;
            r_root[0] <= '0;
        end
    end

    // square root, one result bit per stage
    for (genvar gs = 1; gs <= D; gs++) begin : g_sqrt
        localparam logic [SW-1:0] BITV = SW'(1) << (2*(D-gs));
        logic [SW-1:0] w_trial;
        assign w_trial = r_root[gs-1] + BITV;
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                if (r_acc[gs-1] >= w_trial) begin
                    r_acc[gs]  <= r_acc[gs-1] - w_trial;
                    r_root[gs] <= (r_root[gs-1] >> 1) + BITV;
                end else begin
                    r_acc[gs]  <= r_acc[gs-1];
                    r_root[gs] <= r_root[gs-1] >> 1;
                end
            end
        end
    end

    // length and numerators
    assign w_root = r_root[D][D-1:0];
    always_comb begin
        w_len = r_hv[P_L-1] ? {w_root, 1'b0} : {1'b0, w_root};
        if (w_len == '0) begin
            w_len = LW'(1);
        end
    end
    assign w_px = r_mx[P_L-1] * i_half_width;
    assign w_py = r_my[P_L-1] * i_half_width;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_len   <= w_len;
            r_px    <= w_px;
            r_py    <= w_py;
            r_dl[0] <= r_len;
            r_rx[0] <= NW'(r_px) + NW'(r_len >> 1);
            r_ry[0] <= NW'(r_py) + NW'(r_len >> 1);
            r_qx[0] <= '0;
            r_qy[0] <= '0;
        end
    end

    // restoring divide, one quotient bit per stage, x and y share the divisor
    for (genvar gj = 1; gj <= QB; gj++) begin : g_div
        localparam int SH = QB - gj;
        logic [NW-1:0] w_dsh;
        logic          w_gx, w_gy;
        assign w_dsh = NW'(r_dl[gj-1]) << SH;
        assign w_gx  = (r_rx[gj-1] >= w_dsh);
        assign w_gy  = (r_ry[gj-1] >= w_dsh);
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dl[gj] <= r_dl[gj-1];
                r_rx[gj] <= w_gx ? (r_rx[gj-1] - w_dsh) : r_rx[gj-1];
                r_ry[gj] <= w_gy ? (r_ry[gj-1] - w_dsh) : r_ry[gj-1];
                r_qx[gj] <= {r_qx[gj-1][QB-2:0], w_gx};
                r_qy[gj] <= {r_qy[gj-1][QB-2:0], w_gy};
            end
        end
    end

    // heel scaling of the unit vector
    assign w_hpx = r_qx[QB] * i_heel + HPW'(128);
    assign w_hpy = r_qy[QB] * i_heel + HPW'(128);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_nx <= r_qx[QB];
            r_ny <= r_qy[QB];
            r_hx <= w_hpx[HPW-1:8];
            r_hy <= w_hpy[HPW-1:8];
        end
    end

    // corners
    always_comb begin
        logic signed [OW-1:0] x1, y1, x2, y2, w, e3, nx, ny, hx, hy, a1, a2, b1, b2;
        x1 = OW'(r_x1[P_H]);
        y1 = OW'(r_y1[P_H]);
        x2 = OW'(r_x2[P_H]);
        y2 = OW'(r_y2[P_H]);
        w  = OW'($signed({1'b0, i_half_width}));
        e3 = OW'($signed({1'b0, i_e3}));
        nx = OW'($signed({1'b0, r_nx}));
        ny = OW'($signed({1'b0, r_ny}));
        hx = OW'($signed({1'b0, r_hx}));
        hy = OW'($signed({1'b0, r_hy}));
        if (r_dn[P_H]) begin
            ny = -ny;
            hy = -hy;
        end
        case (r_kd[P_H])
            tsq_pkg::KIND_VERT: begin
                a1 = y1 - pick_ext(r_c1[P_H], w, e3);
                a2 = y2 + pick_ext(r_c2[P_H], w, e3);
                w_cr[0] = x1 - w; w_cr[1] = a1;
                w_cr[2] = x2 - w; w_cr[3] = a2;
                w_cr[4] = x2 + w; w_cr[5] = a2;
                w_cr[6] = x1 + w; w_cr[7] = a1;
            end
            tsq_pkg::KIND_HORZ: begin
                a1 = x1 - pick_ext(r_c1[P_H], w, e3);
                a2 = x2 + pick_ext(r_c2[P_H], w, e3);
                w_cr[0] = a1; w_cr[1] = y1 - w;
                w_cr[2] = a2; w_cr[3] = y2 - w;
                w_cr[4] = a2; w_cr[5] = y2 + w;
                w_cr[6] = a1; w_cr[7] = y1 + w;
            end
            default: begin
                a1 = x1 - pick_ext(r_c1[P_H], nx, hx);
                b1 = y1 - pick_ext(r_c1[P_H], ny, hy);
                a2 = x2 + pick_ext(r_c2[P_H], nx, hx);
                b2 = y2 + pick_ext(r_c2[P_H], ny, hy);
                w_cr[0] = a1 + ny; w_cr[1] = b1 - nx;
                w_cr[2] = a2 + ny; w_cr[3] = b2 - nx;
                w_cr[4] = a2 - ny; w_cr[5] = b2 + nx;
                w_cr[6] = a1 - ny; w_cr[7] = b1 + nx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 8; k++) begin
                r_odata[k*C +: C] <= sat(w_cr[k]);
            end
        end
    end

endmodule

/* hw/rtl/thick_stroke_to_quad_core.sv */
// Stroke segment to quadrilateral corners, fully pipelined.
// From an input beat to its output beat: one front register, the queue, a COORD_BITS + 1
// stage square root, a 15 stage divider, squaring, heel and corner stages.
// Throughput: one segment per cycle while the output is not stalled; every square root
// and divide step has its own stage.
// Reset (i_rst_n, synchronous, active low) empties the pipe and the queue and
// restores half_width = 1280 and heel_factor = 768.
module thick_stroke_to_quad_core #(
    parameter int COORD_BITS = tsq_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // start_x, start_y, end_x, end_y, start_cap, end_cap, zero pad to bytes
    input  logic [((4*COORD_BITS+15)/8)*8-1:0] s_tdata,
    // output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // corner_a_x, corner_a_y, corner_b_x, corner_b_y, corner_c_x, corner_c_y,
    // corner_d_x, corner_d_y, zero pad to bytes
    output logic [((8*COORD_BITS+7)/8)*8-1:0] m_tdata,
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tsq_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int C   = COORD_BITS;
    localparam int D   = C + 1;
    localparam int EW  = 4*C + 11 + 2*D;
    localparam int OTW = ((8*C+7)/8)*8;
    localparam int HWB = tsq_pkg::HALF_W_BITS;
    localparam int HFB = tsq_pkg::HEEL_F_BITS;
    localparam int EPW = HWB + HFB + 1;

    logic [HWB-1:0]               r_half_width;
    logic [HFB-1:0]               r_heel;
    logic [tsq_pkg::HEEL_BITS-1:0] r_e3;
    logic [EPW-1:0]               w_e3p;
    logic                         w_wr;
    tsq_pkg::t_reg                w_reg;

    logic                         w_push, w_full, w_pop, w_nempty;
    logic [EW-1:0]                w_went, w_rent;
    logic [8*C-1:0]               w_odata;

    // register port: writes land in the access phase, reads are combinational
    assign pready = 1'b1;
    assign w_reg  = tsq_pkg::t_reg'(paddr[2]);
    assign w_wr   = psel && penable && pwrite;

    always_comb begin
        unique case (w_reg)
            tsq_pkg::REG_HALF_WIDTH:  prdata = 32'(r_half_width);
            tsq_pkg::REG_HEEL_FACTOR: prdata = 32'(r_heel);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width <= tsq_pkg::HALF_W_RESET;
            r_heel       <= tsq_pkg::HEEL_F_RESET;
        end else if (w_wr) begin
            unique case (w_reg)
                tsq_pkg::REG_HALF_WIDTH:  r_half_width <= pwdata[HWB-1:0];
                tsq_pkg::REG_HEEL_FACTOR: r_heel       <= pwdata[HFB-1:0];
                default: ;
            endcase
        end
    end

    // heel extension for axis strokes, round(W * H / 256); refresh every cycle
    assign w_e3p = r_half_width * r_heel + EPW'(128);
    always_ff @(posedge i_clk) begin
        r_e3 <= tsq_pkg::HEEL_BITS'(w_e3p[EPW-1:8]);
    end

    // front: order the endpoints and classify the stroke
    tsq_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_data  (s_tdata[4*C+7:0]),
        .o_push  (w_push),
        .i_full  (w_full),
        .o_ent   (w_went)
    );

    // queue decouples the front from output stalls
    tsq_fifo #(
        .WIDTH(EW),
        .DEPTH(tsq_pkg::FIFO_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_wdata  (w_went),
        .o_full   (w_full),
        .i_pop    (w_pop),
        .o_rdata  (w_rent),
        .o_nempty (w_nempty)
    );

    // back: length, unit vector, extensions, corners
    tsq_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ent_valid  (w_nempty),
        .o_pop        (w_pop),
        .i_ent        (w_rent),
        .i_half_width (r_half_width),
        .i_heel       (r_heel),
        .i_e3         (r_e3),
        .o_valid      (m_tvalid),
        .i_ready      (m_tready),
        .o_data       (w_odata)
    );

    assign m_tdata = OTW'(w_odata);

endmodule

/* hw/rtl/tsq_chk.sv */
module tsq_chk #(
    parameter int COORD_BITS = tsq_pkg::COORD_BITS_DEF
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [((4*COORD_BITS+15)/8)*8-1:0] s_tdata,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [((8*COORD_BITS+7)/8)*8-1:0]  m_tdata,
    input logic                               psel,
    input logic                               penable,
    input logic                               pwrite,
    input logic [tsq_pkg::ADDR_BITS-1:0]      paddr,
    input logic [31:0]                        pwdata,
    input logic [31:0]                        prdata,
    input logic                               pready
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // reset drops any result and opens the input
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid && s_tready)
        else $error("pipe not empty after reset");

    // written half width reads back
    a_hw_rb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && !paddr[2]) ##1 (psel && !pwrite && !paddr[2])
        |-> prdata[tsq_pkg::HALF_W_BITS-1:0] ==
            $past(pwdata[tsq_pkg::HALF_W_BITS-1:0]))
        else $error("half width readback mismatch");

    // no result appears after a reset cycle followed by an idle input cycle
    a_no_spur: assert property (@(posedge i_clk)
        !i_rst_n ##1 !s_tvalid |=> !m_tvalid)
        else $error("result without an input beat");

endmodule

bind thick_stroke_to_quad_core tsq_chk #(.COORD_BITS(COORD_BITS)) u_tsq_chk (.*);

/* test/tb_thick_stroke_to_quad_core.sv */
`timescale 1ns / 1ps

// Stroke-to-quad corners: APB register writes between phases, directed
// strokes first, then random strokes against a local predictor.
class quad_scoreboard;
    typedef struct packed {
        logic [19:0] dy, dx, cy, cx, by, bx, ay, ax;
    } corners_t;

    corners_t pending_q[$];
    int       n_errors;
    logic [13:0] half_w;
    logic [11:0] heel_f;

    function new();
        n_errors = 0;
        half_w = tsq_pkg::HALF_W_RESET;
        heel_f = tsq_pkg::HEEL_F_RESET;
    endfunction

    static function longint sx20(logic [19:0] v);
        return longint'(signed'(v));
    endfunction

    static function logic [19:0] clamp20(longint v);
        if (v > 524287) v = 524287;
        if (v < -524288) v = -524288;
        return v[19:0];
    endfunction

    // round(a*f/256) with ties away from zero
    static function longint heel_scale(longint a, longint f);
        longint m;
        m = (a < 0) ? -a : a;
        m = (m * f + 128) >>> 8;
        return (a < 0) ? -m : m;
    endfunction

    static function longint norm_scale(longint a, longint w, longint l);
        longint m;
        m = (a < 0) ? -a : a;
        m = (m * w + l / 2) / l;
        return (a < 0) ? -m : m;
    endfunction

    static function longint int_sqrt(longint s);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > s) b = b >>> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    // note an accepted stroke beat: predict its corners
    function void note_stroke(logic [87:0] d);
        longint ax, ay, bx, by, x1, y1, x2, y2, w, e3, dx, dy, len, nx, ny;
        logic [3:0] ca, cb, c1, c2;
        bit swap;
        corners_t c;
        ax = sx20(d[19:0]); ay = sx20(d[39:20]);
        bx = sx20(d[59:40]); by = sx20(d[79:60]);
        ca = d[83:80]; cb = d[87:84];
        w = half_w;
        e3 = heel_scale(w, heel_f);
        swap = (ax == bx) ? (ay > by) : (ax > bx);
        if (swap) begin
            x1 = bx; y1 = by; x2 = ax; y2 = ay; c1 = cb; c2 = ca;
        end else begin
            x1 = ax; y1 = ay; x2 = bx; y2 = by; c1 = ca; c2 = cb;
        end
        if (ax == bx) begin
            if (c1 == tsq_pkg::CAP_EXT) y1 -= w;
            if (c2 == tsq_pkg::CAP_EXT) y2 += w;
            if (c1 == tsq_pkg::CAP_HEEL) y1 -= e3;
            if (c2 == tsq_pkg::CAP_HEEL) y2 += e3;
            c.ax = clamp20(x1 - w); c.ay = clamp20(y1);
            c.bx = clamp20(x2 - w); c.by = clamp20(y2);
            c.cx = clamp20(x2 + w); c.cy = clamp20(y2);
            c.dx = clamp20(x1 + w); c.dy = clamp20(y1);
        end else if (ay == by) begin
            if (c1 == tsq_pkg::CAP_EXT) x1 -= w;
            if (c2 == tsq_pkg::CAP_EXT) x2 += w;
            if (c1 == tsq_pkg::CAP_HEEL) x1 -= e3;
            if (c2 == tsq_pkg::CAP_HEEL) x2 += e3;
            c.ax = clamp20(x1); c.ay = clamp20(y1 - w);
            c.bx = clamp20(x2); c.by = clamp20(y2 - w);
            c.cx = clamp20(x2); c.cy = clamp20(y2 + w);
            c.dx = clamp20(x1); c.dy = clamp20(y1 + w);
        end else begin
            dx = x2 - x1; dy = y2 - y1;
            len = int_sqrt(dx * dx + dy * dy);
            if (len == 0) len = 1;
            nx = norm_scale(dx, w, len);
            ny = norm_scale(dy, w, len);
            if (c1 == tsq_pkg::CAP_EXT) begin x1 -= nx; y1 -= ny; end
            if (c2 == tsq_pkg::CAP_EXT) begin x2 += nx; y2 += ny; end
            if (c1 == tsq_pkg::CAP_HEEL) begin
                x1 -= heel_scale(nx, heel_f); y1 -= heel_scale(ny, heel_f);
            end
            if (c2 == tsq_pkg::CAP_HEEL) begin
                x2 += heel_scale(nx, heel_f); y2 += heel_scale(ny, heel_f);
            end
            // offset is (ny, -nx)
            c.ax = clamp20(x1 + ny); c.ay = clamp20(y1 - nx);
            c.bx = clamp20(x2 + ny); c.by = clamp20(y2 - nx);
            c.cx = clamp20(x2 - ny); c.cy = clamp20(y2 + nx);
            c.dx = clamp20(x1 - ny); c.dy = clamp20(y1 + nx);
        end
        pending_q.push_back(c);
    endfunction

    function void check_field(string name, logic [19:0] exp_v, logic [19:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, signed'(exp_v), signed'(act_v));
            n_errors++;
        end
    endfunction

    function void check_corners(logic [159:0] d);
        corners_t e, a;
        if (pending_q.size() == 0) begin
            $error("corner beat with no stroke pending");
            n_errors++;
            return;
        end
        e = pending_q.pop_front();
        a = d;
        check_field("corner_a_x", e.ax, a.ax);
        check_field("corner_a_y", e.ay, a.ay);
        check_field("corner_b_x", e.bx, a.bx);
        check_field("corner_b_y", e.by, a.by);
        check_field("corner_c_x", e.cx, a.cx);
        check_field("corner_c_y", e.cy, a.cy);
        check_field("corner_d_x", e.dx, a.dx);
        check_field("corner_d_y", e.dy, a.dy);
    endfunction
endclass

module tb_thick_stroke_to_quad_core;

    localparam int  LATENCY   = 20 + 23;
    localparam longint CYCLE_LIMIT = 400000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // start_x, start_y, end_x, end_y, start_cap, end_cap
    logic [87:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // corner_a_x, corner_a_y, ... corner_d_x, corner_d_y
    logic [159:0] m_tdata;
    logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [tsq_pkg::ADDR_BITS-1:0] paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    quad_scoreboard board = new();
    longint n_cycles = 0;
    bit     sink_calm = 1'b0;  // no output stalls in the final stretch
    bit     src_calm = 1'b0;

    thick_stroke_to_quad_core i_dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // count cycles and give up far past the slowest correct run
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("tb_thick_stroke_to_quad_core: errors");
            $finish;
        end
    end

    // sample accepted beats at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && s_tvalid && s_tready) board.note_stroke(s_tdata);
        if (i_rst_n && m_tvalid && m_tready) board.check_corners(m_tdata);
    end

    // output side: stall in random bursts
    initial begin
        int n;
        @(negedge i_clk);
        forever begin
            if (!sink_calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 5);
                repeat (n) @(negedge i_clk);
            end else begin
                m_tready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    // APB write with setup and access phases; register lands on the access edge
    task automatic write_reg(tsq_pkg::t_reg idx, logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= tsq_pkg::ADDR_BITS'(4 * int'(idx)); pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == tsq_pkg::REG_HALF_WIDTH) board.half_w = value[13:0];
        else board.heel_f = value[11:0];
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // hold one stroke beat until accepted, with an optional idle burst first
    task automatic send_stroke(logic [19:0] ax, ay, bx, by, logic [3:0] ca, cb);
        int n;
        if (!src_calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            n = $urandom_range(1, 5);
            repeat (n) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {cb, ca, by, bx, ay, ax};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.pending_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
    endtask

    function automatic logic [19:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return 20'($urandom);
            1: return $urandom_range(0, 1) ? 20'h7FFFF : 20'h80000;
            default: return 20'($signed($urandom_range(0, 8000)) - 4000);
        endcase
    endfunction

    function automatic logic [3:0] rand_cap();
        return $urandom_range(0, 1) ? 4'($urandom_range(2, 3)) : 4'($urandom);
    endfunction

    // random strokes: vertical, horizontal, coincident and diagonal mixes
    task automatic random_strokes(int count);
        logic [19:0] ax, ay, bx, by;
        for (int k = 0; k < count; k++) begin
            ax = rand_coord(); ay = rand_coord();
            bx = rand_coord(); by = rand_coord();
            case ($urandom_range(0, 5))
                0: bx = ax;
                1: by = ay;
                2: begin bx = ax; by = ay; end
                default: ;
            endcase
            send_stroke(ax, ay, bx, by, rand_cap(), rand_cap());
        end
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: each stroke kind, swapping, caps, extremes, saturation
        send_stroke(20'd100, 20'd900, 20'd100, 20'd50, tsq_pkg::CAP_EXT, tsq_pkg::CAP_HEEL);
        send_stroke(20'd900, 20'd70, 20'd10, 20'd70, tsq_pkg::CAP_HEEL, tsq_pkg::CAP_EXT);
        send_stroke(20'd0, 20'd0, 20'd768, 20'd1024, tsq_pkg::CAP_EXT, tsq_pkg::CAP_EXT);
        send_stroke(20'd768, 20'd1024, 20'd0, 20'd0, tsq_pkg::CAP_HEEL, tsq_pkg::CAP_HEEL);
        send_stroke(20'd5, 20'd5, 20'd5, 20'd5, tsq_pkg::CAP_EXT, tsq_pkg::CAP_HEEL);
        send_stroke(20'h7FFFF, 20'h7FFFF, 20'h80000, 20'h80000,
                    tsq_pkg::CAP_EXT, tsq_pkg::CAP_EXT);
        send_stroke(20'h80000, 20'h7FFFF, 20'h7FFFF, 20'h80000,
                    tsq_pkg::CAP_HEEL, tsq_pkg::CAP_HEEL);
        send_stroke(20'h7FFFF, 20'h80000, 20'h7FFFF, 20'h7FFFF,
                    tsq_pkg::CAP_EXT, tsq_pkg::CAP_EXT);
        send_stroke(20'h80000, 20'd0, 20'h7FFFF, 20'd0, tsq_pkg::CAP_HEEL, tsq_pkg::CAP_EXT);
        send_stroke(20'd10, 20'd20, 20'd11, 20'd21, 4'd15, 4'd10);
        send_stroke(20'd10, 20'd20, 20'd300, 20'd1, 4'd0, 4'd9);
        send_stroke(20'hFFFFF, 20'hAAAAA, 20'h55555, 20'h00001, 4'd1, 4'd4);
        // pause the sender until all corners are back
        settle();

        write_reg(tsq_pkg::REG_HALF_WIDTH, 32'd16383);
        write_reg(tsq_pkg::REG_HEEL_FACTOR, 32'd4095);
        random_strokes(150);
        settle();
        write_reg(tsq_pkg::REG_HALF_WIDTH, 32'd0);
        write_reg(tsq_pkg::REG_HEEL_FACTOR, 32'd0);
        random_strokes(100);
        settle();
        write_reg(tsq_pkg::REG_HALF_WIDTH, 32'($urandom_range(1, 16382)));
        write_reg(tsq_pkg::REG_HEEL_FACTOR, 32'($urandom_range(1, 4094)));
        random_strokes(300);
        settle();
        write_reg(tsq_pkg::REG_HALF_WIDTH, 32'd1280);
        write_reg(tsq_pkg::REG_HEEL_FACTOR, 32'd768);
        random_strokes(250);
        // last stretch: both sides run flat out
        src_calm = 1'b1;
        sink_calm = 1'b1;
        random_strokes(150);
        settle();

        if (board.n_errors == 0 && board.pending_q.size() == 0) begin
            $display("tb_thick_stroke_to_quad_core: clean");
        end else begin
            $display("tb_thick_stroke_to_quad_core: errors");
        end
        $finish;
    end
endmodule
